// ===== rtl/pcode_stack_machine_step_macros.svh =====
// Assertion macros shared by the p-code stack machine RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef PCODE_STACK_MACHINE_STEP_MACROS_SVH
`define PCODE_STACK_MACHINE_STEP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCSM_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcsm same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PCSM_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcsm next-cycle check failed");

`endif

// ===== rtl/pcsm_pkg.sv =====
// Shared types, codes and helpers of the p-code stack machine.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pcsm_pkg;

  localparam int MEM_WORDS_DEFAULT  = 512;
  localparam int MAX_LEVELS_DEFAULT = 16;

  // Address arithmetic runs in a signed word wide enough for a 32-bit link plus a 32-bit offset.
  localparam int XW = 34;
  typedef logic signed [XW-1:0] xaddr_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_OUT   = 3'd1,
    ST_HALT  = 3'd2,
    ST_BADOP = 3'd3,
    ST_DIV0  = 3'd4,
    ST_RANGE = 3'd5,
    ST_IDLE  = 3'd6
  } status_t;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STEP  = 2'd2;

  localparam logic [31:0] OP_LIT = 32'd1;
  localparam logic [31:0] OP_OPR = 32'd2;
  localparam logic [31:0] OP_LOD = 32'd3;
  localparam logic [31:0] OP_STO = 32'd4;
  localparam logic [31:0] OP_CAL = 32'd5;
  localparam logic [31:0] OP_INC = 32'd6;
  localparam logic [31:0] OP_JMP = 32'd7;
  localparam logic [31:0] OP_JPC = 32'd8;
  localparam logic [31:0] OP_SYS = 32'd9;

  localparam logic [31:0] OPR_RTN = 32'd0;
  localparam logic [31:0] OPR_ADD = 32'd1;
  localparam logic [31:0] OPR_SUB = 32'd2;
  localparam logic [31:0] OPR_MUL = 32'd3;
  localparam logic [31:0] OPR_DIV = 32'd4;
  localparam logic [31:0] OPR_EQL = 32'd5;
  localparam logic [31:0] OPR_NEQ = 32'd6;
  localparam logic [31:0] OPR_LSS = 32'd7;
  localparam logic [31:0] OPR_LEQ = 32'd8;
  localparam logic [31:0] OPR_GTR = 32'd9;
  localparam logic [31:0] OPR_GEQ = 32'd10;

  localparam logic [31:0] SYS_WRT = 32'd1;
  localparam logic [31:0] SYS_RED = 32'd2;
  localparam logic [31:0] SYS_HLT = 32'd3;

  typedef enum logic [4:0] {
    UOP_NONE,
    UOP_IDLE,
    UOP_DISPATCH,
    UOP_FETCH1,
    UOP_FETCH2,
    UOP_FETCH3,
    UOP_DECODE,
    UOP_RTN_RD,
    UOP_RTN_BP,
    UOP_RTN_PC,
    UOP_AR_RD,
    UOP_AR_A,
    UOP_AR_B,
    UOP_ALU,
    UOP_DIV_STEP,
    UOP_DIV_END,
    UOP_TOP_RD,
    UOP_TOP_USE,
    UOP_WALK_RD,
    UOP_WALK_LAT,
    UOP_POST_RD,
    UOP_POST_USE,
    UOP_CHECK,
    UOP_WRITE,
    UOP_COMMIT,
    UOP_FAULT,
    UOP_PEEK0,
    UOP_PEEK1,
    UOP_PEEK2,
    UOP_OUT_LOAD
  } uop_t;

  typedef enum logic [2:0] {
    CLS_SIMPLE,
    CLS_RTN,
    CLS_ALU,
    CLS_TOP,
    CLS_WALK,
    CLS_BADOP
  } cls_t;

  typedef struct packed {
    uop_t    uop;
    status_t fault;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       running;
    logic       fetch_bad;
    cls_t       cls;
    logic       l_bad;
    logic       rtn_bad;
    logic       ar_bad;
    logic       is_div;
    logic       b_zero;
    logic       div_done;
    logic       top_bad;
    logic       walk_done;
    logic       walk_bad;
    logic       post_bad;
    logic       is_cal;
    logic       chk_bad;
    logic       wr_done;
    logic       peek_ok;
  } stat_t;

  function automatic xaddr_t sext32(input logic [31:0] w);
    return {{(XW-32){w[31]}}, w};
  endfunction

endpackage

// ===== rtl/pcsm_ram.sv =====
// Generic single-port word memory with registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module pcsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/pcsm_ctrl.sv =====
// Instruction sequencer of the p-code stack machine.
// Depends on pcsm_pkg for the command and status structs.
`timescale 1ns / 1ps

module pcsm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  pcsm_pkg::stat_t stat,
  output pcsm_pkg::cmd_t  cmd
);
  import pcsm_pkg::*;

  typedef enum logic [28:0] {
    S_IDLE   = 29'(1) << 0,
    S_DISP   = 29'(1) << 1,
    S_F1     = 29'(1) << 2,
    S_F2     = 29'(1) << 3,
    S_F3     = 29'(1) << 4,
    S_DEC    = 29'(1) << 5,
    S_RTN0   = 29'(1) << 6,
    S_RTN1   = 29'(1) << 7,
    S_RTN2   = 29'(1) << 8,
    S_AR0    = 29'(1) << 9,
    S_AR1    = 29'(1) << 10,
    S_AR2    = 29'(1) << 11,
    S_AR3    = 29'(1) << 12,
    S_DIV    = 29'(1) << 13,
    S_DIVE   = 29'(1) << 14,
    S_TOP0   = 29'(1) << 15,
    S_TOP1   = 29'(1) << 16,
    S_WALK   = 29'(1) << 17,
    S_WALKL  = 29'(1) << 18,
    S_POST   = 29'(1) << 19,
    S_POSTU  = 29'(1) << 20,
    S_CHK    = 29'(1) << 21,
    S_WR     = 29'(1) << 22,
    S_COMMIT = 29'(1) << 23,
    S_FAULT  = 29'(1) << 24,
    S_PEEK0  = 29'(1) << 25,
    S_PEEK1  = 29'(1) << 26,
    S_PEEK2  = 29'(1) << 27,
    S_OUT    = 29'(1) << 28
  } state_t;

  state_t  state, state_next;
  status_t fault_code, fault_code_next;
  uop_t    uop;
  logic    load_out;

  always_comb begin
    state_next      = state;
    fault_code_next = fault_code;
    uop             = UOP_NONE;
    load_out        = 1'b0;
    case (state)
      S_IDLE: begin
        uop = UOP_IDLE;
        if (in_valid) begin
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        uop = UOP_DISPATCH;
        if (stat.kind == KIND_STEP && stat.running) begin
          if (stat.fetch_bad) begin
            fault_code_next = ST_RANGE;
            state_next      = S_FAULT;
          end else begin
            state_next = S_F1;
          end
        end else begin
          state_next = S_PEEK0;
        end
      end
      S_F1: begin
        uop        = UOP_FETCH1;
        state_next = S_F2;
      end
      S_F2: begin
        uop        = UOP_FETCH2;
        state_next = S_F3;
      end
      S_F3: begin
        uop        = UOP_FETCH3;
        state_next = S_DEC;
      end
      S_DEC: begin
        uop = UOP_DECODE;
        case (stat.cls)
          CLS_SIMPLE: state_next = S_CHK;
          CLS_RTN:    state_next = S_RTN0;
          CLS_ALU:    state_next = S_AR0;
          CLS_TOP:    state_next = S_TOP0;
          CLS_WALK: begin
            if (stat.l_bad) begin
              fault_code_next = ST_RANGE;
              state_next      = S_FAULT;
            end else begin
              state_next = S_WALK;
            end
          end
          default: begin
            fault_code_next = ST_BADOP;
            state_next      = S_FAULT;
          end
        endcase
      end
      S_RTN0: begin
        uop = UOP_RTN_RD;
        if (stat.rtn_bad) begin
          fault_code_next = ST_RANGE;
          state_next      = S_FAULT;
        end else begin
          state_next = S_RTN1;
        end
      end
      S_RTN1: begin
        uop        = UOP_RTN_BP;
        state_next = S_RTN2;
      end
      S_RTN2: begin
        uop        = UOP_RTN_PC;
        state_next = S_CHK;
      end
      S_AR0: begin
        uop = UOP_AR_RD;
        if (stat.ar_bad) begin
          fault_code_next = ST_RANGE;
          state_next      = S_FAULT;
        end else begin
          state_next = S_AR1;
        end
      end
      S_AR1: begin
        uop        = UOP_AR_A;
        state_next = S_AR2;
      end
      S_AR2: begin
        uop        = UOP_AR_B;
        state_next = S_AR3;
      end
      S_AR3: begin
        uop = UOP_ALU;
        if (!stat.is_div) begin
          state_next = S_CHK;
        end else if (stat.b_zero) begin
          fault_code_next = ST_DIV0;
          state_next      = S_FAULT;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        uop = UOP_DIV_STEP;
        if (stat.div_done) begin
          state_next = S_DIVE;
        end
      end
      S_DIVE: begin
        uop        = UOP_DIV_END;
        state_next = S_CHK;
      end
      S_TOP0: begin
        uop = UOP_TOP_RD;
        if (stat.top_bad) begin
          fault_code_next = ST_RANGE;
          state_next      = S_FAULT;
        end else begin
          state_next = S_TOP1;
        end
      end
      S_TOP1: begin
        uop        = UOP_TOP_USE;
        state_next = S_CHK;
      end
      S_WALK: begin
        uop = UOP_WALK_RD;
        if (stat.walk_done) begin
          state_next = S_POST;
        end else if (stat.walk_bad) begin
          fault_code_next = ST_RANGE;
          state_next      = S_FAULT;
        end else begin
          state_next = S_WALKL;
        end
      end
      S_WALKL: begin
        uop        = UOP_WALK_LAT;
        state_next = S_WALK;
      end
      S_POST: begin
        uop = UOP_POST_RD;
        if (stat.post_bad) begin
          fault_code_next = ST_RANGE;
          state_next      = S_FAULT;
        end else if (stat.is_cal) begin
          state_next = S_CHK;
        end else begin
          state_next = S_POSTU;
        end
      end
      S_POSTU: begin
        uop        = UOP_POST_USE;
        state_next = S_CHK;
      end
      S_CHK: begin
        uop = UOP_CHECK;
        if (stat.chk_bad) begin
          fault_code_next = ST_RANGE;
          state_next      = S_FAULT;
        end else begin
          state_next = S_WR;
        end
      end
      S_WR: begin
        uop = UOP_WRITE;
        if (stat.wr_done) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        uop        = UOP_COMMIT;
        state_next = S_PEEK0;
      end
      S_FAULT: begin
        uop        = UOP_FAULT;
        state_next = S_PEEK0;
      end
      S_PEEK0: begin
        uop = UOP_PEEK0;
        if (stat.peek_ok) begin
          state_next = S_PEEK1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_PEEK1: begin
        uop        = UOP_PEEK1;
        state_next = S_PEEK2;
      end
      S_PEEK2: begin
        uop        = UOP_PEEK2;
        state_next = S_OUT;
      end
      S_OUT: begin
        // The result register is refilled in the same cycle that the old result leaves.
        if (!out_valid || !out_stall) begin
          uop        = UOP_OUT_LOAD;
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fault_code <= ST_OK;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fault_code <= fault_code_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign cmd.uop   = uop;
  assign cmd.fault = fault_code;

endmodule

// ===== rtl/pcsm_dpath.sv =====
// Datapath of the p-code stack machine: registers, word memory, ALU, divider, result register.
// Depends on pcsm_pkg and pcsm_ram.
`timescale 1ns / 1ps

module pcsm_dpath #(
  parameter int MEM_WORDS  = pcsm_pkg::MEM_WORDS_DEFAULT,
  parameter int MAX_LEVELS = pcsm_pkg::MAX_LEVELS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  pcsm_pkg::cmd_t     cmd,
  output pcsm_pkg::stat_t    stat,
  input  logic [1:0]         op,
  input  logic [8:0]         address,
  input  logic signed [31:0] data,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_data,
  output logic [2:0]         status,
  output logic signed [31:0] value,
  output logic               wants_input,
  output logic [8:0]         pc_now,
  output logic [8:0]         bp_now,
  output logic signed [9:0]  sp_now
);
  import pcsm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);
  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam xaddr_t MEMW = xaddr_t'(MEM_WORDS);
  localparam logic signed [31:0] MAXL = 32'(MAX_LEVELS);

  function automatic logic in_mem(input xaddr_t x);
    return (x >= xaddr_t'(0)) && (x < MEMW);
  endfunction

  // Item and control registers.
  logic [1:0]       kind_w;
  logic [8:0]       addr_w;
  logic [31:0]      data_w;
  logic [AW-1:0]    pc, bp;
  logic signed [AW:0] sp;
  logic             running;
  logic [8:0]       code_length;

  // Instruction work registers.
  logic [31:0] op_w, l_w, m_w, a_w, b_w;
  xaddr_t      npc, nbp, nsp, cursor;
  logic [LW-1:0] lev_cnt;
  xaddr_t      wa [3];
  logic [31:0] wv [3];
  logic [1:0]  nw, wr_idx;
  status_t     st_pend, res_status;
  logic [31:0] res_value;
  logic        res_wants, flag9;

  // Restoring divider on magnitudes.
  logic [32:0] dv_rem;
  logic [31:0] dv_quo, dv_ub;
  logic        dv_neg;
  logic [4:0]  dv_cnt;
  logic [32:0] rem_sh;

  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [31:0]   ram_wdata, rdata;

  xaddr_t pc_x, bp_x, sp_x, m_x, pc1_x, pc2_x, pc3_x, bp1_x, bp2_x, bpm1_x;
  xaddr_t spm1_x, spp1_x, spp2_x, spp3_x, ea_x, addr_x, cl_x, clm1_x;
  cls_t   cls;
  logic [31:0] alu_r, ua, ubv;

  assign pc_x   = xaddr_t'(pc);
  assign bp_x   = xaddr_t'(bp);
  assign sp_x   = xaddr_t'(sp);
  assign m_x    = sext32(m_w);
  assign pc1_x  = pc_x + xaddr_t'(1);
  assign pc2_x  = pc_x + xaddr_t'(2);
  assign pc3_x  = pc_x + xaddr_t'(3);
  assign bp1_x  = bp_x + xaddr_t'(1);
  assign bp2_x  = bp_x + xaddr_t'(2);
  assign bpm1_x = bp_x - xaddr_t'(1);
  assign spm1_x = sp_x - xaddr_t'(1);
  assign spp1_x = sp_x + xaddr_t'(1);
  assign spp2_x = sp_x + xaddr_t'(2);
  assign spp3_x = sp_x + xaddr_t'(3);
  assign ea_x   = cursor + m_x;
  assign addr_x = xaddr_t'(addr_w);
  assign cl_x   = xaddr_t'(code_length);
  assign clm1_x = cl_x - xaddr_t'(1);

  always_comb begin
    case (op_w)
      OP_LIT, OP_INC, OP_JMP: cls = CLS_SIMPLE;
      OP_OPR: begin
        if (m_w == OPR_RTN) begin
          cls = CLS_RTN;
        end else if ($signed(m_w) >= $signed(OPR_ADD) && $signed(m_w) <= $signed(OPR_GEQ)) begin
          cls = CLS_ALU;
        end else begin
          cls = CLS_SIMPLE;
        end
      end
      OP_LOD, OP_STO, OP_CAL: cls = CLS_WALK;
      OP_JPC: cls = CLS_TOP;
      OP_SYS: cls = (m_w == SYS_WRT) ? CLS_TOP : CLS_SIMPLE;
      default: cls = CLS_BADOP;
    endcase
  end

  always_comb begin
    case (m_w)
      OPR_ADD: alu_r = a_w + b_w;
      OPR_SUB: alu_r = a_w - b_w;
      OPR_MUL: alu_r = a_w * b_w;
      OPR_EQL: alu_r = 32'(a_w == b_w);
      OPR_NEQ: alu_r = 32'(a_w != b_w);
      OPR_LSS: alu_r = 32'($signed(a_w) < $signed(b_w));
      OPR_LEQ: alu_r = 32'($signed(a_w) <= $signed(b_w));
      OPR_GTR: alu_r = 32'($signed(a_w) > $signed(b_w));
      default: alu_r = 32'($signed(a_w) >= $signed(b_w));
    endcase
  end

  assign ua     = a_w[31] ? (32'd0 - a_w) : a_w;
  assign ubv    = b_w[31] ? (32'd0 - b_w) : b_w;
  assign rem_sh = {dv_rem[31:0], dv_quo[31]};

  always_comb begin
    stat.kind      = kind_w;
    stat.running   = running;
    stat.fetch_bad = !in_mem(pc2_x);
    stat.cls       = cls;
    stat.l_bad     = $signed(l_w) > MAXL;
    stat.rtn_bad   = !in_mem(bp1_x) || !in_mem(bp2_x);
    stat.ar_bad    = !in_mem(spm1_x) || !in_mem(sp_x);
    stat.is_div    = (m_w == OPR_DIV);
    stat.b_zero    = (b_w == 32'd0);
    stat.div_done  = (dv_cnt == 5'd31);
    stat.top_bad   = !in_mem(sp_x);
    stat.walk_done = (lev_cnt == '0);
    stat.walk_bad  = !in_mem(cursor);
    stat.is_cal    = (op_w == OP_CAL);
    case (op_w)
      OP_LOD:  stat.post_bad = !in_mem(ea_x);
      OP_STO:  stat.post_bad = !in_mem(sp_x);
      default: stat.post_bad = 1'b0;
    endcase
    stat.chk_bad = !in_mem(npc) || !in_mem(nbp) || (nsp < xaddr_t'(-1)) || (nsp >= MEMW)
                 || ((nw > 2'd0) && !in_mem(wa[0]))
                 || ((nw > 2'd1) && !in_mem(wa[1]))
                 || ((nw > 2'd2) && !in_mem(wa[2]));
    stat.wr_done = (wr_idx == nw);
    stat.peek_ok = running && in_mem(pc2_x);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pc;
    ram_wdata = data_w;
    case (cmd.uop)
      UOP_DISPATCH: begin
        if (kind_w == KIND_LOAD) begin
          ram_addr = addr_x[AW-1:0];
          ram_we   = in_mem(addr_x);
        end
      end
      UOP_FETCH1:  ram_addr = pc1_x[AW-1:0];
      UOP_FETCH2:  ram_addr = pc2_x[AW-1:0];
      UOP_RTN_RD:  ram_addr = bp1_x[AW-1:0];
      UOP_RTN_BP:  ram_addr = bp2_x[AW-1:0];
      UOP_AR_RD:   ram_addr = spm1_x[AW-1:0];
      UOP_AR_A:    ram_addr = sp_x[AW-1:0];
      UOP_TOP_RD:  ram_addr = sp_x[AW-1:0];
      UOP_WALK_RD: ram_addr = cursor[AW-1:0];
      UOP_POST_RD: ram_addr = (op_w == OP_LOD) ? ea_x[AW-1:0] : sp_x[AW-1:0];
      UOP_WRITE: begin
        ram_addr  = wa[wr_idx][AW-1:0];
        ram_wdata = wv[wr_idx];
        ram_we    = (wr_idx != nw);
      end
      UOP_PEEK1:   ram_addr = pc2_x[AW-1:0];
      default:     ram_addr = pc;
    endcase
  end

  pcsm_ram #(
    .WIDTH (32),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  // Architectural registers and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= '0;
      bp          <= '0;
      sp          <= '1;
      running     <= 1'b0;
      code_length <= '0;
    end else begin
      if (cfg_we) begin
        code_length <= cfg_data;
      end
      case (cmd.uop)
        UOP_DISPATCH: begin
          if (kind_w == KIND_START && in_mem(cl_x)) begin
            pc      <= '0;
            bp      <= cl_x[AW-1:0];
            sp      <= clm1_x[AW:0];
            running <= 1'b1;
          end
        end
        UOP_COMMIT: begin
          pc <= npc[AW-1:0];
          bp <= nbp[AW-1:0];
          sp <= nsp[AW:0];
          if (st_pend == ST_HALT) begin
            running <= 1'b0;
          end
        end
        UOP_FAULT: running <= 1'b0;
        default: ;
      endcase
    end
  end

  // Work registers, divider and result register.
  always_ff @(posedge clk) begin
    case (cmd.uop)
      UOP_IDLE: begin
        kind_w <= op;
        addr_w <= address;
        data_w <= data;
      end
      UOP_DISPATCH: begin
        res_status <= ST_OK;
        res_value  <= '0;
        res_wants  <= 1'b0;
        case (kind_w)
          KIND_LOAD: begin
            if (!in_mem(addr_x)) begin
              res_status <= ST_RANGE;
            end
          end
          KIND_START: begin
            if (!in_mem(cl_x)) begin
              res_status <= ST_RANGE;
            end
          end
          KIND_STEP: begin
            if (!running) begin
              res_status <= ST_IDLE;
            end
          end
          default: ;
        endcase
      end
      UOP_FETCH1: op_w <= rdata;
      UOP_FETCH2: l_w  <= rdata;
      UOP_FETCH3: m_w  <= rdata;
      UOP_DECODE: begin
        npc     <= pc3_x;
        nbp     <= bp_x;
        nsp     <= sp_x;
        nw      <= 2'd0;
        st_pend <= ST_OK;
        cursor  <= bp_x;
        lev_cnt <= ($signed(l_w) <= 0) ? '0 : l_w[LW-1:0];
        case (op_w)
          OP_LIT: begin
            nsp   <= spp1_x;
            wa[0] <= spp1_x;
            wv[0] <= m_w;
            nw    <= 2'd1;
          end
          OP_INC: nsp <= sp_x + m_x;
          OP_JMP: npc <= m_x;
          OP_SYS: begin
            if (m_w == SYS_RED) begin
              nsp   <= spp1_x;
              wa[0] <= spp1_x;
              wv[0] <= data_w;
              nw    <= 2'd1;
            end else if (m_w == SYS_HLT) begin
              st_pend <= ST_HALT;
            end
          end
          default: ;
        endcase
      end
      UOP_RTN_BP: nbp <= sext32(rdata);
      UOP_RTN_PC: begin
        npc <= sext32(rdata);
        nsp <= bpm1_x;
      end
      UOP_AR_A: a_w <= rdata;
      UOP_AR_B: b_w <= rdata;
      UOP_ALU: begin
        wa[0]  <= spm1_x;
        wv[0]  <= alu_r;
        nsp    <= spm1_x;
        nw     <= 2'd1;
        dv_rem <= '0;
        dv_quo <= ua;
        dv_ub  <= ubv;
        dv_neg <= a_w[31] ^ b_w[31];
        dv_cnt <= '0;
      end
      UOP_DIV_STEP: begin
        if (rem_sh >= {1'b0, dv_ub}) begin
          dv_rem <= rem_sh - {1'b0, dv_ub};
          dv_quo <= {dv_quo[30:0], 1'b1};
        end else begin
          dv_rem <= rem_sh;
          dv_quo <= {dv_quo[30:0], 1'b0};
        end
        dv_cnt <= dv_cnt + 5'd1;
      end
      UOP_DIV_END: wv[0] <= dv_neg ? (32'd0 - dv_quo) : dv_quo;
      UOP_TOP_USE: begin
        nsp <= spm1_x;
        if (op_w == OP_JPC) begin
          if (rdata == 32'd0) begin
            npc <= m_x;
          end
        end else begin
          res_value <= rdata;
          st_pend   <= ST_OUT;
        end
      end
      UOP_WALK_LAT: begin
        cursor  <= sext32(rdata);
        lev_cnt <= lev_cnt - LW'(1);
      end
      UOP_POST_RD: begin
        if (op_w == OP_CAL) begin
          // Frame: static link, dynamic link, return address.
          wa[0] <= spp1_x;
          wv[0] <= cursor[31:0];
          wa[1] <= spp2_x;
          wv[1] <= bp_x[31:0];
          wa[2] <= spp3_x;
          wv[2] <= npc[31:0];
          nw    <= 2'd3;
          nbp   <= spp1_x;
          npc   <= m_x;
        end
      end
      UOP_POST_USE: begin
        nw    <= 2'd1;
        wv[0] <= rdata;
        if (op_w == OP_LOD) begin
          wa[0] <= spp1_x;
          nsp   <= spp1_x;
        end else begin
          wa[0] <= ea_x;
          nsp   <= spm1_x;
        end
      end
      UOP_CHECK: wr_idx <= 2'd0;
      UOP_WRITE: begin
        if (wr_idx != nw) begin
          wr_idx <= wr_idx + 2'd1;
        end
      end
      UOP_COMMIT: res_status <= st_pend;
      UOP_FAULT: begin
        res_status <= cmd.fault;
        res_value  <= '0;
      end
      UOP_PEEK0: begin
        if (!(running && in_mem(pc2_x))) begin
          res_wants <= 1'b0;
        end
      end
      UOP_PEEK1: flag9 <= (rdata == OP_SYS);
      UOP_PEEK2: res_wants <= flag9 && (rdata == SYS_RED);
      UOP_OUT_LOAD: begin
        status      <= res_status;
        value       <= res_value;
        wants_input <= res_wants;
        pc_now      <= pc_x[8:0];
        bp_now      <= bp_x[8:0];
        sp_now      <= sp_x[9:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/pcode_stack_machine_step.sv =====
// Top level of the PL/0 p-code stack machine: sequencer plus datapath.
// Depends on pcsm_pkg, pcsm_ctrl, pcsm_dpath and the assertion macro header.
//
// Usage: items enter on in_valid/in_stall with fields op, address and data.
// op 0 loads a program word, op 1 starts a run (pc 0, bp and sp from
// code_length), op 2 executes one instruction. Every item yields exactly one
// result on out_valid/out_stall: status, value, wants_input and the pc, bp
// and sp after the item. code_length is written on cfg_valid/cfg_ready (always
// high); the user must write it only while idle, not enforced by the block.
// One item is worked on at a time; in_stall is high from acceptance until the
// result is placed in the output register. A step fetches its three words,
// decodes, does the work of its class (JPC or WRT, RTN, LOD, STO, CAL or
// the ALU group), follows the static links one at a time, runs the bit-serial
// divider for DIV, then checks, writes its words one at a time and commits.
// A step that stops the machine skips the two RED check reads, and a fault
// ends early. The single port of the word memory sets the pace: one access
// per cycle. A waiting result does not block acceptance of the next item; a
// finished item waits in its final state while the receiver stalls.
// Synchronous reset clears pc, bp, running and code_length and sets sp to -1;
// memory contents are undefined until loaded.
`timescale 1ns / 1ps
`include "pcode_stack_machine_step_macros.svh"

module pcode_stack_machine_step #(
  parameter int MEM_WORDS  = pcsm_pkg::MEM_WORDS_DEFAULT,
  parameter int MAX_LEVELS = pcsm_pkg::MAX_LEVELS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [8:0]         address,
  input  logic signed [31:0] data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] value,
  output logic               wants_input,
  output logic [8:0]         pc_now,
  output logic [8:0]         bp_now,
  output logic signed [9:0]  sp_now,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [8:0]         cfg_data
);
  import pcsm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  pcsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pcsm_dpath #(
    .MEM_WORDS  (MEM_WORDS),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (op),
    .address     (address),
    .data        (data),
    .cfg_we      (cfg_valid),
    .cfg_data    (cfg_data),
    .status      (status),
    .value       (value),
    .wants_input (wants_input),
    .pc_now      (pc_now),
    .bp_now      (bp_now),
    .sp_now      (sp_now)
  );

  // A stopped machine never asks for input.
  `PCSM_ASSERT_IMPL(a_stopped_no_input, clk, rst,
    out_valid && (status == ST_BADOP || status == ST_DIV0 || status == ST_IDLE || status == ST_HALT),
    !wants_input)
  // Only a WRT result carries a value.
  `PCSM_ASSERT_IMPL(a_value_only_on_output, clk, rst,
    out_valid && (status != ST_OUT), value == 32'sd0)
  // The sequencer is busy right after taking an item.
  `PCSM_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule
